// ----- rtl/core/variable_record_event_log_ring_defines.svh -----
// Assertion helpers for the event log ring checker.
`ifndef VARIABLE_RECORD_EVENT_LOG_RING_DEFINES_SVH
`define VARIABLE_RECORD_EVENT_LOG_RING_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VREL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define VREL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/vrel_pkg.sv -----
package vrel_pkg;

	localparam int HDR_BYTES = 4;
	localparam int OUT_CAP   = 32;

	localparam int FUNC_W = 2;
	localparam int ID_W   = 16;
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 6;
	localparam int IDX_W  = 5;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;
	localparam int M_TUSER_W = 2;

	localparam logic [FUNC_W-1:0] FN_BEGIN = 2'd0;
	localparam logic [FUNC_W-1:0] FN_DATA  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_QUERY = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [BYTE_W-1:0] event_type;
		logic [LEN_W-1:0]  payload_length;
		logic [BYTE_W-1:0] data_byte;
		logic [ID_W-1:0]   after_id;
	} item_t;

	typedef struct packed {
		logic              event_found;
		logic              id_matched;
		logic [ID_W-1:0]   event_id;
		logic [BYTE_W-1:0] record_type;
		logic [LEN_W-1:0]  record_length;
		logic [BYTE_W-1:0] payload_byte;
		logic [IDX_W-1:0]  byte_index;
		logic              last;
	} res_t;

endpackage

// ----- rtl/core/vrel_ram.sv -----
module vrel_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [vrel_pkg::BYTE_W-1:0] wr_data,
	input  logic [AW-1:0]               rd_addr,
	output logic [vrel_pkg::BYTE_W-1:0] rd_data
);
	import vrel_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/core/vrel_ctrl.sv -----
module vrel_ctrl #(
	parameter int RING_BYTES  = 1024,
	parameter int MAX_PAYLOAD = 32,
	parameter int POS_W       = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  vrel_pkg::item_t             item,
	output logic                        res_valid,
	input  logic                        res_ready,
	output vrel_pkg::res_t              res,
	output logic [POS_W-1:0]            rd_addr,
	input  logic [vrel_pkg::BYTE_W-1:0] rd_data,
	output logic                        wr_en,
	output logic [POS_W-1:0]            wr_addr,
	output logic [vrel_pkg::BYTE_W-1:0] wr_data
);
	import vrel_pkg::*;

	localparam int USED_W = $clog2(RING_BYTES + 1);
	localparam int OFF_W  = USED_W + 1;
	localparam int SUM_W  = USED_W + 1;
	localparam int SIZE_W = LEN_W + 1;

	localparam logic [SUM_W-1:0]  RING_S = SUM_W'(RING_BYTES);
	localparam logic [LEN_W-1:0]  MAXP6  = LEN_W'(MAX_PAYLOAD);
	localparam logic [BYTE_W-1:0] MAXP8  = BYTE_W'(MAX_PAYLOAD);
	localparam logic [LEN_W-1:0]  CAP6   = LEN_W'(OUT_CAP);
	localparam logic [SIZE_W-1:0] HDR7   = SIZE_W'(HDR_BYTES);

	typedef enum logic [3:0] {
		ST_IDLE, ST_EV, ST_EVW, ST_HDR,
		ST_WALK, ST_W1, ST_W2, ST_W3,
		ST_R0, ST_R1, ST_R2, ST_R3, ST_R4,
		ST_PRD, ST_PCAP, ST_PUSH
	} state_t;

	state_t             state_q;
	logic [POS_W-1:0]   oldest_q;
	logic [USED_W-1:0]  used_q;
	logic [ID_W-1:0]    next_id_q;
	logic [LEN_W-1:0]   pending_q;
	logic [POS_W-1:0]   write_pos_q;
	logic [POS_W-1:0]   cur_q;
	logic [POS_W-1:0]   pay_pos_q;
	logic [OFF_W-1:0]   off_q;
	logic [SIZE_W-1:0]  size_q;
	logic [1:0]         hdr_idx_q;
	logic [ID_W-1:0]    after_q;
	logic [ID_W-1:0]    rec_id_q;
	logic [BYTE_W-1:0]  rec_type_q;
	logic [LEN_W-1:0]   rec_len_q;
	logic [LEN_W-1:0]   n_q;
	logic [IDX_W-1:0]   idx_q;
	logic [BYTE_W-1:0]  pbyte_q;
	logic               found_q;
	logic               matched_q;

	logic               accept;
	logic               res_last;
	logic [LEN_W-1:0]   in_len;
	logic [LEN_W-1:0]   rd_len;
	logic [SIZE_W-1:0]  rd_rec;

	// Position add modulo ring size; the sum stays below twice the ring.
	function automatic logic [POS_W-1:0] pos_add(input logic [POS_W-1:0] pos,
	                                             input logic [USED_W-1:0] inc);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(pos) + SUM_W'(inc);
		if (sum >= RING_S) begin
			sum = sum - RING_S;
		end
		return sum[POS_W-1:0];
	endfunction

	function automatic logic [LEN_W-1:0] clamp_byte(input logic [BYTE_W-1:0] b);
		logic [LEN_W-1:0] r;
		r = (b > MAXP8) ? MAXP6 : b[LEN_W-1:0];
		return r;
	endfunction

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign in_len   = (item.payload_length > MAXP6) ? MAXP6 : item.payload_length;
	assign rd_len   = clamp_byte(rd_data);
	assign rd_rec   = HDR7 + SIZE_W'(rd_len);
	assign res_last = ((LEN_W'(idx_q) + LEN_W'(1)) == n_q);

	assign res_valid = (state_q == ST_PUSH);
	always_comb begin
		res.event_found   = found_q;
		res.id_matched    = matched_q;
		res.event_id      = rec_id_q;
		res.record_type   = rec_type_q;
		res.record_length = rec_len_q;
		res.payload_byte  = pbyte_q;
		res.byte_index    = idx_q;
		res.last          = res_last;
	end

	always_comb begin
		unique case (state_q)
			ST_EV:   rd_addr = pos_add(oldest_q, USED_W'(3));
			ST_W1:   rd_addr = pos_add(cur_q, USED_W'(1));
			ST_W2:   rd_addr = pos_add(cur_q, USED_W'(3));
			ST_R1:   rd_addr = pos_add(cur_q, USED_W'(1));
			ST_R2:   rd_addr = pos_add(cur_q, USED_W'(2));
			ST_R3:   rd_addr = pos_add(cur_q, USED_W'(3));
			ST_PRD:  rd_addr = pay_pos_q;
			default: rd_addr = cur_q;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = write_pos_q;
		wr_data = item.data_byte;
		if (state_q == ST_HDR) begin
			wr_en   = 1'b1;
			wr_addr = cur_q;
			case (hdr_idx_q)
				2'd0:    wr_data = rec_id_q[7:0];
				2'd1:    wr_data = rec_id_q[15:8];
				2'd2:    wr_data = rec_type_q;
				default: wr_data = BYTE_W'(rec_len_q);
			endcase
		end else if (accept && item.func == FN_DATA && pending_q != '0) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			oldest_q    <= '0;
			used_q      <= '0;
			next_id_q   <= ID_W'(1);
			pending_q   <= '0;
			write_pos_q <= '0;
			found_q     <= 1'b0;
			matched_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.func)
							FN_BEGIN: begin
								rec_id_q   <= next_id_q;
								rec_type_q <= item.event_type;
								rec_len_q  <= in_len;
								size_q     <= HDR7 + SIZE_W'(in_len);
								next_id_q  <= next_id_q + ID_W'(1);
								state_q    <= ST_EV;
							end
							FN_DATA: begin
								if (pending_q != '0) begin
									write_pos_q <= pos_add(write_pos_q, USED_W'(1));
									pending_q   <= pending_q - LEN_W'(1);
								end
							end
							FN_QUERY: begin
								after_q   <= item.after_id;
								off_q     <= '0;
								cur_q     <= oldest_q;
								found_q   <= 1'b0;
								matched_q <= 1'b0;
								state_q   <= ST_WALK;
							end
							default: ;
						endcase
					end
				end
				// Evict the oldest record while the new one does not fit.
				ST_EV: begin
					if (used_q != '0 && (SUM_W'(used_q) + SUM_W'(size_q)) > RING_S) begin
						state_q <= ST_EVW;
					end else begin
						cur_q     <= pos_add(oldest_q, used_q);
						hdr_idx_q <= 2'd0;
						state_q   <= ST_HDR;
					end
				end
				ST_EVW: begin
					if (OFF_W'(rd_rec) >= OFF_W'(used_q)) begin
						oldest_q <= pos_add(oldest_q, used_q);
						used_q   <= '0;
					end else begin
						oldest_q <= pos_add(oldest_q, USED_W'(rd_rec));
						used_q   <= used_q - USED_W'(rd_rec);
					end
					state_q <= ST_EV;
				end
				ST_HDR: begin
					cur_q     <= pos_add(cur_q, USED_W'(1));
					hdr_idx_q <= hdr_idx_q + 2'd1;
					if (hdr_idx_q == 2'd3) begin
						write_pos_q <= pos_add(cur_q, USED_W'(1));
						used_q      <= used_q + USED_W'(size_q);
						pending_q   <= rec_len_q;
						state_q     <= ST_IDLE;
					end
				end
				// Walk headers: the record after a match is the target, or the oldest one when no id matches.
				ST_WALK: begin
					if (off_q >= OFF_W'(used_q)) begin
						if (!matched_q && used_q != '0) begin
							found_q <= 1'b1;
							cur_q   <= oldest_q;
							state_q <= ST_R0;
						end else begin
							rec_id_q   <= '0;
							rec_type_q <= '0;
							rec_len_q  <= '0;
							pbyte_q    <= '0;
							idx_q      <= '0;
							n_q        <= LEN_W'(1);
							state_q    <= ST_PUSH;
						end
					end else if (matched_q) begin
						found_q <= 1'b1;
						state_q <= ST_R0;
					end else begin
						state_q <= ST_W1;
					end
				end
				ST_W1: begin
					rec_id_q[7:0] <= rd_data;
					state_q       <= ST_W2;
				end
				ST_W2: begin
					rec_id_q[15:8] <= rd_data;
					state_q        <= ST_W3;
				end
				ST_W3: begin
					if (rec_id_q == after_q) begin
						matched_q <= 1'b1;
					end
					off_q   <= off_q + OFF_W'(rd_rec);
					cur_q   <= pos_add(cur_q, USED_W'(rd_rec));
					state_q <= ST_WALK;
				end
				ST_R0: state_q <= ST_R1;
				ST_R1: begin
					rec_id_q[7:0] <= rd_data;
					state_q       <= ST_R2;
				end
				ST_R2: begin
					rec_id_q[15:8] <= rd_data;
					state_q        <= ST_R3;
				end
				ST_R3: begin
					rec_type_q <= rd_data;
					state_q    <= ST_R4;
				end
				ST_R4: begin
					rec_len_q <= rd_len;
					idx_q     <= '0;
					pay_pos_q <= pos_add(cur_q, USED_W'(HDR_BYTES));
					if (rd_len == '0) begin
						pbyte_q <= '0;
						n_q     <= LEN_W'(1);
						state_q <= ST_PUSH;
					end else begin
						n_q     <= (rd_len > CAP6) ? CAP6 : rd_len;
						state_q <= ST_PRD;
					end
				end
				ST_PRD: state_q <= ST_PCAP;
				ST_PCAP: begin
					pbyte_q <= rd_data;
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (res_ready) begin
						if (res_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q     <= idx_q + IDX_W'(1);
							pay_pos_q <= pos_add(pay_pos_q, USED_W'(1));
							state_q   <= ST_PRD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/variable_record_event_log_ring.sv -----
// Event log holding variable-length records (4-byte header: id low, id high, type,
// length; then the payload) end to end in a single-port-read, single-port-write byte
// ring with a registered read. Words are taken one at a time, only while the
// sequencer is idle. A payload word is written without leaving the idle state. An
// append begin evicts the oldest records while the new one does not fit, each
// eviction reading one length byte from the ring, then writes the four header bytes.
// A query walks the record headers (three ring reads per header, then one closing
// check), fetches the returned header, and then reads each payload result word,
// waiting while the output stalls; a record without payload gives a single result,
// and a query with nothing to return skips the header fetch. The results leave through
// an output register, so the next word can be taken while the last result of a query
// still waits.
module variable_record_event_log_ring #(
	parameter int RING_BYTES  = 1024,
	parameter int MAX_PAYLOAD = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// event_type[7:0], payload_length[13:8], data_byte[21:14], after_id[37:22]
	input  logic [vrel_pkg::S_TDATA_W-1:0] s_tdata,
	// func[1:0]
	input  logic [vrel_pkg::FUNC_W-1:0]    s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// event_id[15:0], record_type[23:16], record_length[29:24], payload_byte[37:30],
	// byte_index[42:38]
	output logic [vrel_pkg::M_TDATA_W-1:0] m_tdata,
	// event_found[0], id_matched[1]
	output logic [vrel_pkg::M_TUSER_W-1:0] m_tuser,
	output logic                           m_tlast
);
	import vrel_pkg::*;

	localparam int POS_W = $clog2(RING_BYTES);

	item_t             item;
	res_t              res;
	res_t              out_q;
	logic              out_valid_q;
	logic              res_valid;
	logic              res_ready;
	logic [POS_W-1:0]  rd_addr;
	logic [POS_W-1:0]  wr_addr;
	logic [BYTE_W-1:0] rd_data;
	logic [BYTE_W-1:0] wr_data;
	logic              wr_en;

	always_comb begin
		item.func           = s_tuser;
		item.event_type     = s_tdata[7:0];
		item.payload_length = s_tdata[13:8];
		item.data_byte      = s_tdata[21:14];
		item.after_id       = s_tdata[37:22];
	end

	vrel_ram #(
		.DEPTH (RING_BYTES),
		.AW    (POS_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	vrel_ctrl #(
		.RING_BYTES  (RING_BYTES),
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.POS_W       (POS_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.item      (item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// Load a new word when the output slot is empty or drains this cycle.
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_q.byte_index, out_q.payload_byte, out_q.record_length,
	                   out_q.record_type, out_q.event_id};
	assign m_tuser  = {out_q.id_matched, out_q.event_found};
	assign m_tlast  = out_q.last;

endmodule

// ----- rtl/core/vrel_checker.sv -----
`include "variable_record_event_log_ring_defines.svh"

module vrel_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [vrel_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [vrel_pkg::M_TUSER_W-1:0] m_tuser,
	input logic                           m_tlast
);
	import vrel_pkg::*;

	logic                         stalled;
	logic                         empty_result;
	logic                         no_payload;
	logic                         has_payload;
	logic                         mid_query;
	logic [LEN_W-1:0]             rec_len;
	logic [LEN_W-1:0]             idx_wide;
	logic [M_TDATA_W+M_TUSER_W:0] out_word;

	assign rec_len      = m_tdata[29:24];
	assign idx_wide     = LEN_W'(m_tdata[42:38]);
	assign out_word     = {m_tlast, m_tuser, m_tdata};
	assign stalled      = m_tvalid && !m_tready;
	assign empty_result = m_tvalid && !m_tuser[0];
	assign no_payload   = m_tvalid && m_tuser[0] && rec_len == '0;
	assign has_payload  = m_tvalid && m_tuser[0] && rec_len != '0;
	// a non-last word in the output slot means the query still has words to make
	assign mid_query    = m_tvalid && !m_tlast;

	`VREL_ASSERT_NEXT(a_out_hold, stalled, m_tvalid && $stable(out_word), "word changed while stalled")
	`VREL_ASSERT_NOW(a_empty_zero, empty_result, m_tlast && m_tdata == '0, "not-found word not clean")
	`VREL_ASSERT_NOW(a_nopay_single, no_payload, m_tlast && m_tdata[42:30] == '0, "empty record word")
	`VREL_ASSERT_NOW(a_idx_range, has_payload, idx_wide < rec_len, "byte index beyond length")
	`VREL_ASSERT_NOW(a_query_busy, mid_query, !s_tready, "input open in the middle of a query")

endmodule

bind variable_record_event_log_ring vrel_checker u_vrel_checker (.*);

// ----- sim/event_log_ring_check.sv -----
`timescale 1ns / 1ps

module event_log_ring_check #(
	parameter int RING_BYTES  = 1024,
	parameter int MAX_PAYLOAD = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	// event_type[7:0], payload_length[13:8], data_byte[21:14], after_id[37:22]
	input  logic [vrel_pkg::S_TDATA_W-1:0] s_tdata,
	// func[1:0]
	input  logic [vrel_pkg::FUNC_W-1:0]    s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	// event_id[15:0], record_type[23:16], record_length[29:24], payload_byte[37:30],
	// byte_index[42:38]
	input  logic [vrel_pkg::M_TDATA_W-1:0] m_tdata,
	// event_found[0], id_matched[1]
	input  logic [vrel_pkg::M_TUSER_W-1:0] m_tuser,
	input  logic                           m_tlast,
	output int                             fails,
	output int                             waiting
);
	import vrel_pkg::*;

	logic [7:0]  ring_mem [RING_BYTES];
	int unsigned head_pos;
	int unsigned fill;
	logic [15:0] id_ctr;
	int unsigned owed;
	int unsigned wr_pos;

	res_t  due_results [$];
	item_t word;
	res_t  seen;
	res_t  want;

	initial begin
		fails   = 0;
		waiting = 0;
	end

	task automatic note_fault(input string msg);
		if (fails < 40)
			$display("%0t ns: %s", $time, msg);
		fails++;
	endtask

	task automatic cmp(input string name, input logic [15:0] got_v, input logic [15:0] want_v);
		if (got_v !== want_v)
			note_fault($sformatf("%s: got %0h, expected %0h", name, got_v, want_v));
	endtask

	function automatic logic [7:0] rec_byte(input int unsigned off);
		return ring_mem[(head_pos + off) % RING_BYTES];
	endfunction

	function automatic int unsigned rec_len(input int unsigned off);
		int unsigned l;
		l = rec_byte(off + 3);
		return l > MAX_PAYLOAD ? MAX_PAYLOAD : l;
	endfunction

	function automatic logic [15:0] rec_id(input int unsigned off);
		return {rec_byte(off + 1), rec_byte(off)};
	endfunction

	function automatic void log_append(input logic [7:0] ty, input logic [5:0] plen);
		int unsigned ln;
		int unsigned size;
		int unsigned rec;
		int unsigned base;
		ln = plen > MAX_PAYLOAD ? MAX_PAYLOAD : plen;
		size = HDR_BYTES + ln;
		// evict oldest records until the new one fits
		while (fill > 0 && fill + size > RING_BYTES) begin
			rec = HDR_BYTES + rec_len(0);
			if (rec >= fill) begin
				head_pos = (head_pos + fill) % RING_BYTES;
				fill = 0;
			end else begin
				head_pos = (head_pos + rec) % RING_BYTES;
				fill -= rec;
			end
		end
		base = head_pos + fill;
		ring_mem[base % RING_BYTES]       = id_ctr[7:0];
		ring_mem[(base + 1) % RING_BYTES] = id_ctr[15:8];
		ring_mem[(base + 2) % RING_BYTES] = ty;
		ring_mem[(base + 3) % RING_BYTES] = 8'(ln);
		wr_pos = (base + HDR_BYTES) % RING_BYTES;
		fill += size;
		owed = ln;
		id_ctr = id_ctr + 16'd1;
	endfunction

	function automatic void log_payload(input logic [7:0] db);
		if (owed > 0) begin
			ring_mem[wr_pos] = db;
			wr_pos = (wr_pos + 1) % RING_BYTES;
			owed--;
		end
	endfunction

	function automatic void log_lookup(input logic [15:0] after);
		int unsigned off;
		int unsigned target;
		int unsigned ln;
		int unsigned n;
		bit hit;
		bit got;
		res_t r;
		off = 0;
		target = 0;
		hit = 1'b0;
		got = 1'b0;
		while (off < fill) begin
			if (hit) begin
				got = 1'b1;
				target = off;
				break;
			end
			if (rec_id(off) == after)
				hit = 1'b1;
			off += HDR_BYTES + rec_len(off);
		end
		// absent id falls back to the oldest record
		if (!got && !hit && fill > 0)
			got = 1'b1;
		r = '0;
		r.id_matched = hit;
		r.last = 1'b1;
		if (!got) begin
			due_results.push_back(r);
			return;
		end
		r.event_found = 1'b1;
		r.event_id = rec_id(target);
		r.record_type = rec_byte(target + 2);
		ln = rec_len(target);
		if (ln == 0) begin
			due_results.push_back(r);
			return;
		end
		n = ln > OUT_CAP ? OUT_CAP : ln;
		r.record_length = LEN_W'(ln);
		for (int unsigned i = 0; i < n; i++) begin
			r.payload_byte = rec_byte(target + HDR_BYTES + i);
			r.byte_index = IDX_W'(i);
			r.last = (i + 1 == n);
			due_results.push_back(r);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_pos = 0;
			fill = 0;
			id_ctr = 16'd1;
			owed = 0;
			wr_pos = 0;
			due_results.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				word.func = s_tuser;
				word.event_type = s_tdata[7:0];
				word.payload_length = s_tdata[13:8];
				word.data_byte = s_tdata[21:14];
				word.after_id = s_tdata[37:22];
				case (word.func)
					FN_BEGIN: log_append(word.event_type, word.payload_length);
					FN_DATA:  log_payload(word.data_byte);
					FN_QUERY: log_lookup(word.after_id);
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				seen.event_found = m_tuser[0];
				seen.id_matched = m_tuser[1];
				seen.event_id = m_tdata[15:0];
				seen.record_type = m_tdata[23:16];
				seen.record_length = m_tdata[29:24];
				seen.payload_byte = m_tdata[37:30];
				seen.byte_index = m_tdata[42:38];
				seen.last = m_tlast;
				if (due_results.size() == 0) begin
					note_fault($sformatf("result %0h/%0h with nothing expected", m_tuser, m_tdata));
				end else begin
					want = due_results.pop_front();
					cmp("event_found", seen.event_found, want.event_found);
					cmp("id_matched", seen.id_matched, want.id_matched);
					cmp("event_id", seen.event_id, want.event_id);
					cmp("record_type", seen.record_type, want.record_type);
					cmp("record_length", seen.record_length, want.record_length);
					cmp("payload_byte", seen.payload_byte, want.payload_byte);
					cmp("byte_index", seen.byte_index, want.byte_index);
					cmp("last", seen.last, want.last);
				end
			end
		end
		waiting = due_results.size();
	end

endmodule

// ----- sim/variable_record_event_log_ring_test.sv -----
`timescale 1ns / 1ps

module variable_record_event_log_ring_test;
	import vrel_pkg::*;

	localparam int RING  = 1024;
	localparam int MAXP  = 32;
	localparam int LIMIT = 5_000_000;
	localparam logic [FUNC_W-1:0] FN_NOP = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [FUNC_W-1:0]    s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic                 m_tlast;
	int                   fails;
	int                   waiting;

	// sender-side view of the log, enough to keep unwritten bytes out of reach
	logic [15:0] id_next = 16'd1;
	int          owed = 0;
	int          laid = 0;
	int          counted = 0;
	bit          steady = 1'b0;
	bit          hold_req = 1'b0;
	bit          hold_taken = 1'b0;
	int          hold_left = 0;
	int          cycles = 0;

	always #1 clk = ~clk;

	variable_record_event_log_ring #(
		.RING_BYTES (RING),
		.MAX_PAYLOAD(MAXP)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	event_log_ring_check #(
		.RING_BYTES (RING),
		.MAX_PAYLOAD(MAXP)
	) check (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.fails   (fails),
		.waiting (waiting)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("FAIL variable_record_event_log_ring");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || $urandom_range(0, 99) >= 31;
		end
	end

	task automatic put_word(input logic [FUNC_W-1:0] fn, input logic [7:0] ty,
			input logic [5:0] len, input logic [7:0] db, input logic [15:0] aid);
		int clamped;
		while (!steady && $urandom_range(0, 99) < 31) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= {2'b00, aid, db, len, ty};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		clamped = len > MAXP ? MAXP : len;
		case (fn)
			FN_BEGIN: begin
				laid += HDR_BYTES + clamped;
				owed = clamped;
				id_next = id_next + 16'd1;
				counted++;
			end
			FN_DATA: begin
				if (owed > 0) begin
					owed--;
					counted++;
				end
			end
			FN_QUERY: counted++;
			default: ;
		endcase
	endtask

	// leave a record unfinished only once the whole ring has been written
	task automatic append_record(input logic [5:0] len, input bit full);
		int n;
		bit may_leave;
		may_leave = laid >= RING;
		put_word(FN_BEGIN, 8'($urandom), len, 8'($urandom), 16'($urandom));
		n = owed;
		if (!full && may_leave && n > 0)
			n = $urandom_range(0, n - 1);
		repeat (n)
			put_word(FN_DATA, 8'($urandom), 6'($urandom), 8'($urandom), 16'($urandom));
	endtask

	function automatic logic [15:0] pick_after();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return id_next - 16'($urandom_range(2, 14));
		if (r < 72)
			return id_next - 16'd1;
		return 16'($urandom);
	endfunction

	task automatic ask(input logic [15:0] aid);
		put_word(FN_QUERY, 8'($urandom), 6'($urandom), 8'($urandom), aid);
	endtask

	task automatic run_mix(input int n);
		int stop;
		int r;
		stop = counted + n;
		while (counted < stop) begin
			r = $urandom_range(0, 99);
			if (r < 38)
				append_record($urandom_range(0, 99) < 70 ? 6'($urandom_range(0, 8)) :
					6'($urandom_range(9, 32)), 1'b1);
			else if (r < 66)
				ask(pick_after());
			else if (r < 78)
				append_record(6'($urandom_range(0, 32)), 1'b0);
			else if (r < 88)
				put_word($urandom_range(0, 1) ? FN_NOP : FN_DATA, 8'($urandom), 6'($urandom),
					8'($urandom), 16'($urandom));
			else
				append_record(6'($urandom_range(33, 63)), 1'b1);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// unused func, stray payload, empty log
		put_word(FN_NOP, 8'hFF, 6'h3F, 8'hFF, 16'hFFFF);
		put_word(FN_DATA, 8'h00, 6'h00, 8'hFF, 16'h0000);
		ask(16'hFFFF);
		// empty payload: newest id, then absent id
		put_word(FN_BEGIN, 8'hFF, 6'd0, 8'h00, 16'h0000);
		ask(16'd1);
		ask(16'd0);
		put_word(FN_BEGIN, 8'h00, 6'd3, 8'h00, 16'h0000);
		put_word(FN_DATA, 8'h00, 6'd0, 8'h00, 16'h0000);
		put_word(FN_DATA, 8'h00, 6'd0, 8'hFF, 16'h0000);
		put_word(FN_DATA, 8'h00, 6'd0, 8'h5A, 16'h0000);
		ask(16'd1);
		ask(16'hFFFF);
		put_word(FN_BEGIN, 8'h3C, 6'd1, 8'h00, 16'h0000);
		put_word(FN_DATA, 8'h00, 6'd0, 8'hA5, 16'h0000);
		ask(16'd2);

		run_mix(70);
		steady = 1'b1;
		run_mix(50);
		steady = 1'b0;
		run_mix(70);
		drain();

		// hold the output while queries pile up behind it
		hold_req = 1'b1;
		repeat (6)
			ask(pick_after());
		run_mix(130);

		s_tvalid <= 1'b0;
		drain();
		repeat (100) @(negedge clk);
		if (fails == 0 && waiting == 0)
			$display("PASS variable_record_event_log_ring");
		else
			$display("FAIL variable_record_event_log_ring");
		$finish;
	end

endmodule

// ----- variable_record_event_log_ring.f -----
+incdir+rtl/core
rtl/core/vrel_pkg.sv
rtl/core/vrel_ram.sv
rtl/core/vrel_ctrl.sv
rtl/core/variable_record_event_log_ring.sv
rtl/core/vrel_checker.sv
sim/event_log_ring_check.sv
sim/variable_record_event_log_ring_test.sv
